>>> rtl/gmhs_pkg.sv
// Shared constants and beat types for the greedy max-halving sum block.
package gmhs_pkg;

  // Store geometry.
  localparam int MAX_BAGS = 1024;
  localparam int ADDR_W   = $clog2(MAX_BAGS);
  localparam int SIZE_W   = ADDR_W + 1;

  // Field widths.
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 48;
  localparam int ROUNDS_W = 16;

  // One input beat.
  typedef struct packed {
    logic [COUNT_W-1:0] bag_count;
    logic               last_bag;
  } gmhs_in_t;

  // One result beat.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               overflow;
  } gmhs_out_t;

endpackage

>>> rtl/gmhs_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module gmhs_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [DATA_W-1:0] rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, registered.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/greedy_max_halving_sum_top.sv
// Heap-based max store with a greedy take-largest-and-halve pass and its sequencer.
// Sequence: a kept bag is sifted up from the end of the heap, one heap level at a time, then
// written; a dropped bag is only flagged. A last bag then runs rounds of root read, take-top and
// sift-down with a final write until the rounds run out, the store empties or the top is zero.
// Throughput: one item at a time; busy stays high until the item is fully processed.
// The result strobe is high for one cycle, in the same cycle that busy falls; the receiver cannot stall it.
// Reset (synchronous, rst_n low) empties the store and clears rounds; no clearing pass.
module greedy_max_halving_sum_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  gmhs_pkg::gmhs_in_t                  in_data,
  output logic                                out_valid,
  output gmhs_pkg::gmhs_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmhs_pkg::ROUNDS_W-1:0]       cfg_data
);

  localparam int AW = gmhs_pkg::ADDR_W;
  localparam int SW = gmhs_pkg::SIZE_W;
  localparam int CW = gmhs_pkg::COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_FIN_UP,
    ST_ROUND_RD,
    ST_ROUND_TOP,
    ST_DN,
    ST_FIN_DN,
    ST_OUT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [SW-1:0]                   size_r, size_nxt;
  logic [AW-1:0]                   pos_r, pos_nxt;
  logic [CW-1:0]                   val_r, val_nxt;
  logic                            last_r, last_nxt;
  logic                            dropped_r, dropped_nxt;
  logic [gmhs_pkg::ROUNDS_W-1:0]   rounds_r;
  logic [gmhs_pkg::ROUNDS_W-1:0]   cnt_r, cnt_nxt;
  logic [gmhs_pkg::TOTAL_W-1:0]    sum_r, sum_nxt;
  logic                            out_valid_r, out_valid_nxt;
  gmhs_pkg::gmhs_out_t             out_data_r, out_data_nxt;

  // RAM port signals.
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [CW-1:0] wdata, rdata_a, rdata_b;

  // Heap index arithmetic.
  logic [AW-1:0] par, par_par, new_parent_of_size;
  logic [SW-1:0] child, child_nxt;
  logic [SW:0]   child_p1, child_nxt_p1;
  logic          have_b, pick_b;
  logic [CW-1:0] big;
  logic [AW-1:0] big_idx;

  gmhs_ram #(
    .DEPTH  (gmhs_pkg::MAX_BAGS),
    .ADDR_W (AW),
    .DATA_W (CW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Parent and child positions for the sift steps.
  always_comb begin
    par                = (pos_r - AW'(1)) >> 1;
    par_par            = (par - AW'(1)) >> 1;
    new_parent_of_size = (size_r[AW-1:0] - AW'(1)) >> 1;
    child              = {pos_r, 1'b1};
    child_p1           = {1'b0, child} + (SW+1)'(1);
    have_b             = child_p1 < {1'b0, size_r};
    pick_b             = have_b && (rdata_b > rdata_a);
    big                = pick_b ? rdata_b : rdata_a;
    big_idx            = pick_b ? child_p1[AW-1:0] : child[AW-1:0];
    child_nxt          = {big_idx, 1'b1};
    child_nxt_p1       = {1'b0, child_nxt} + (SW+1)'(1);
  end

  // Sequencer: sift-up on load, then rounds of take-top and sift-down.
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    dropped_nxt   = dropped_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = val_r;
    raddr_a       = '0;
    raddr_b       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt  = in_data.bag_count;
          last_nxt = in_data.last_bag;
          if (size_r == SW'(gmhs_pkg::MAX_BAGS)) begin
            dropped_nxt = 1'b1;
            if (in_data.last_bag) begin
              cnt_nxt   = rounds_r;
              sum_nxt   = '0;
              state_nxt = ST_ROUND_RD;
            end
          end else begin
            size_nxt = size_r + SW'(1);
            pos_nxt  = size_r[AW-1:0];
            if (size_r == '0) begin
              state_nxt = ST_FIN_UP;
            end else begin
              raddr_a   = new_parent_of_size;
              state_nxt = ST_UP;
            end
          end
        end
      end

      // One heap level per cycle: the parent's value is on rdata_a.
      ST_UP: begin
        if (rdata_a >= val_r) begin
          state_nxt = ST_FIN_UP;
        end else begin
          we      = 1'b1;
          wdata   = rdata_a;
          pos_nxt = par;
          if (par == '0) begin
            state_nxt = ST_FIN_UP;
          end else begin
            raddr_a = par_par;
          end
        end
      end

      ST_FIN_UP: begin
        we = 1'b1;
        if (last_r) begin
          cnt_nxt   = rounds_r;
          sum_nxt   = '0;
          state_nxt = ST_ROUND_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_ROUND_RD: begin
        if (cnt_r == '0 || size_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          raddr_a   = '0;
          state_nxt = ST_ROUND_TOP;
        end
      end

      // Take the root, add it to the total and start sifting its half down; a zero root ends the rounds.
      ST_ROUND_TOP: begin
        if (rdata_a == '0) begin
          state_nxt = ST_OUT;
        end else begin
          sum_nxt = sum_r + gmhs_pkg::TOTAL_W'(rdata_a);
          val_nxt = rdata_a >> 1;
          pos_nxt = '0;
          cnt_nxt = cnt_r - gmhs_pkg::ROUNDS_W'(1);
          if (size_r <= SW'(1)) begin
            state_nxt = ST_FIN_DN;
          end else begin
            raddr_a   = AW'(1);
            raddr_b   = AW'(2);
            state_nxt = ST_DN;
          end
        end
      end

      // One heap level per cycle: both children are on the read ports.
      ST_DN: begin
        if (big <= val_r) begin
          state_nxt = ST_FIN_DN;
        end else begin
          we      = 1'b1;
          wdata   = big;
          pos_nxt = big_idx;
          if (child_nxt >= size_r) begin
            state_nxt = ST_FIN_DN;
          end else begin
            raddr_a = child_nxt[AW-1:0];
            raddr_b = child_nxt_p1[AW-1:0];
          end
        end
      end

      ST_FIN_DN: begin
        we        = 1'b1;
        state_nxt = ST_ROUND_RD;
      end

      ST_OUT: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.total    = sum_r;
        out_data_nxt.overflow = dropped_r;
        size_nxt              = '0;
        dropped_nxt           = 1'b0;
        state_nxt             = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= '0;
      dropped_r   <= 1'b0;
      rounds_r    <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      if (cfg_valid && cfg_ready) begin
        rounds_r <= cfg_data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
  end

endmodule

>>> tb/greedy_max_halving_sum_top_tb.sv
// Self-checking testbench for the greedy max-halving sum block with a heap-based predictor.
module greedy_max_halving_sum_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One pending bag beat; hold makes the driver wait until all totals are back.
  typedef struct packed {
    gmhs_pkg::gmhs_in_t beat;
    logic               hold;
  } bag_item_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  gmhs_pkg::gmhs_in_t            in_data = '0;
  logic                          out_valid;
  gmhs_pkg::gmhs_out_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [gmhs_pkg::ROUNDS_W-1:0] cfg_data = '0;

  // Stimulus and expected totals.
  bag_item_t           bag_q[$];
  gmhs_pkg::gmhs_out_t expected_totals[$];

  // Predictor state: its own heap, fill level, drop flag and round count.
  logic [gmhs_pkg::COUNT_W-1:0]  bag_heap[gmhs_pkg::MAX_BAGS];
  int unsigned                   heap_fill = 0;
  logic                          dropped = 1'b0;
  logic [gmhs_pkg::ROUNDS_W-1:0] rounds_now = '0;

  // Run statistics.
  int                  mismatches = 0;
  int                  bags_accepted = 0;
  int                  totals_checked = 0;
  int                  overflow_sets = 0;
  int                  burst_left = 1;
  int                  gap_left = 0;
  bag_item_t           next_bag;
  gmhs_pkg::gmhs_out_t oldest_total;

  greedy_max_halving_sum_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Load one bag into the predictor heap; on the last bag, run the rounds and queue the total.
  task automatic load_and_score(input gmhs_pkg::gmhs_in_t b);
    int unsigned                  pos;
    int unsigned                  parent;
    int unsigned                  child;
    int unsigned                  r;
    logic [gmhs_pkg::COUNT_W-1:0] v;
    logic [gmhs_pkg::COUNT_W-1:0] top;
    logic [gmhs_pkg::TOTAL_W-1:0] sum;
    gmhs_pkg::gmhs_out_t          res;
    bags_accepted++;
    if (heap_fill >= gmhs_pkg::MAX_BAGS) begin
      dropped = 1'b1;
    end else begin
      // Sift the new bag up from the end of the heap.
      pos = heap_fill;
      v = b.bag_count;
      heap_fill++;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (bag_heap[parent] >= v) break;
        bag_heap[pos] = bag_heap[parent];
        pos = parent;
      end
      bag_heap[pos] = v;
    end
    if (b.last_bag) begin
      sum = '0;
      for (r = 0; r < rounds_now; r++) begin
        if (heap_fill == 0) break;
        top = bag_heap[0];
        // Once the largest count is zero, no later round adds anything.
        if (top == '0) break;
        sum = sum + gmhs_pkg::TOTAL_W'(top);
        // Put back half of the top and sift it down.
        v = top >> 1;
        pos = 0;
        forever begin
          child = 2 * pos + 1;
          if (child >= heap_fill) break;
          if (child + 1 < heap_fill && bag_heap[child + 1] > bag_heap[child]) child++;
          if (bag_heap[child] <= v) break;
          bag_heap[pos] = bag_heap[child];
          pos = child;
        end
        bag_heap[pos] = v;
      end
      res.total = sum;
      res.overflow = dropped;
      expected_totals.push_back(res);
      if (dropped) overflow_sets++;
      heap_fill = 0;
      dropped = 1'b0;
    end
  endtask

  // Random bag count weighted toward zero, all ones and small values.
  function automatic logic [gmhs_pkg::COUNT_W-1:0] rand_count();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel <= 3) return $urandom_range(0, 16);
    return $urandom;
  endfunction

  task automatic push_bag(input logic [gmhs_pkg::COUNT_W-1:0] v, input logic last_b,
                          input logic hold = 1'b0);
    bag_item_t it;
    it.beat.bag_count = v;
    it.beat.last_bag = last_b;
    it.hold = hold;
    bag_q.push_back(it);
  endtask

  // Queue one data set of n random bags; hold applies to its first bag.
  task automatic push_set(input int n, input logic hold);
    int i;
    for (i = 0; i < n; i++) push_bag(rand_count(), i == n - 1, hold && i == 0);
  endtask

  // Wait until every bag is in, every total is back and the block has settled.
  task automatic wait_idle();
    while (bag_q.size() != 0 || start || busy || expected_totals.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Write the rounds register while the block is idle.
  task automatic write_rounds(input logic [gmhs_pkg::ROUNDS_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rounds_now = v;
  endtask

  // Driver: presents queued bags in bursts with random gaps and predicts each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) load_and_score(in_data);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (bag_q.size() == 0 || (bag_q[0].hold && expected_totals.size() != 0)) begin
          start <= 1'b0;
        end else begin
          next_bag = bag_q.pop_front();
          in_data <= next_bag.beat;
          start <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest expected total.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_totals.size() == 0) begin
        $error("result beat with no total expected: total=%0h overflow=%0b",
               out_data.total, out_data.overflow);
        mismatches++;
      end else begin
        oldest_total = expected_totals.pop_front();
        totals_checked++;
        if (out_data.total !== oldest_total.total) begin
          $error("total: expected %0h, got %0h", oldest_total.total, out_data.total);
          mismatches++;
        end
        if (out_data.overflow !== oldest_total.overflow) begin
          $error("overflow: expected %0b, got %0b", oldest_total.overflow, out_data.overflow);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed sets, then random phases.
  initial begin
    int ph;
    int queued;
    int n;
    logic hold;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Rounds at reset value zero: the total is zero and the store still clears.
    push_bag('1, 1'b1);
    push_bag('0, 1'b0);
    push_bag(32'd5, 1'b1);
    wait_idle();

    // One round takes only the largest bag.
    write_rounds(16'd1);
    push_bag('1, 1'b0);
    push_bag('0, 1'b0);
    push_bag(32'd7, 1'b1);
    wait_idle();

    // Zero-count bags, two maximum bags and an ascending set.
    write_rounds(16'd40);
    push_bag('0, 1'b1);
    push_bag('0, 1'b0);
    push_bag('0, 1'b0);
    push_bag('0, 1'b1);
    push_bag('1, 1'b0);
    push_bag('1, 1'b1);
    for (n = 1; n <= 8; n++) push_bag(gmhs_pkg::COUNT_W'(n), n == 8);
    wait_idle();

    // Largest round count on tiny sets.
    write_rounds('1);
    push_bag('1, 1'b1);
    push_bag('1, 1'b0);
    push_bag(32'h8000_0000, 1'b1);
    wait_idle();

    write_rounds('0);
    push_bag(32'd9, 1'b0);
    push_bag(32'd9, 1'b1);
    wait_idle();

    // Random phases with mostly small sets; some sets wait for the pipeline to drain.
    for (ph = 0; ph < 5; ph++) begin
      if (ph == 0) write_rounds(gmhs_pkg::ROUNDS_W'($urandom_range(1, 8)));
      else if ($urandom_range(0, 4) == 0) write_rounds(gmhs_pkg::ROUNDS_W'($urandom_range(300, 3000)));
      else write_rounds(gmhs_pkg::ROUNDS_W'($urandom_range(0, 300)));
      queued = 0;
      while (queued < 95) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        hold = (ph == 1 && queued == 0) || $urandom_range(0, 24) == 0;
        push_set(n, hold);
        queued += n;
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    $display("Checked %0d totals from %0d bags; %0d sets overflowed the store.",
             totals_checked, bags_accepted, overflow_sets);
    $display("Round counts spanned 0 to 65535 over empty, tiny and mid-sized sets.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
